@@ sv/frustum_aabb_cull_core_macros.svh @@
// ---------------------------------------------------------------------------
// frustum_aabb_cull_core_macros
// Assertion macros shared by the frustum culling modules. They expect clk
// and arst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_AABB_CULL_CORE_MACROS_SVH
`define FRUSTUM_AABB_CULL_CORE_MACROS_SVH

// same-cycle implication
`define FAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fac: assertion failed");

// next-cycle implication
`define FAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fac: assertion failed");

`endif

@@ sv/fac_pkg.sv @@
// ---------------------------------------------------------------------------
// fac_pkg
// Types, codes and plane tables for the frustum box culling core.
// ---------------------------------------------------------------------------
package fac_pkg;

	localparam int NUM_PLANES = 6;
	localparam int AXES       = 3;
	localparam int BOX_N      = 2 * AXES;
	localparam int ROW_N      = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TEST = 1'b1;

	localparam logic [1:0] W_COL = 2'd3;

	typedef enum logic [2:0] {
		PL_LEFT,
		PL_RIGHT,
		PL_BOTTOM,
		PL_TOP,
		PL_NEAR,
		PL_FAR
	} plane_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_PASS
	} coef_op_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [1:0] row;
		logic [1:0] col;
	} ctrl_t;

	typedef struct packed {
		logic valid;
		logic visible;
	} res_t;

	function automatic logic [1:0] plane_col(plane_t p);
		logic [1:0] c;
		case (p)
			PL_LEFT, PL_RIGHT: c = 2'd0;
			PL_BOTTOM, PL_TOP: c = 2'd1;
			default:           c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic coef_op_t plane_op(plane_t p);
		coef_op_t o;
		case (p)
			PL_LEFT, PL_BOTTOM:       o = OP_ADD;
			PL_RIGHT, PL_TOP, PL_FAR: o = OP_SUB;
			default:                  o = OP_PASS;
		endcase
		return o;
	endfunction

endpackage

@@ sv/fac_cell.sv @@
// ---------------------------------------------------------------------------
// fac_cell
// One plane of the culling chain: keeps its plane coefficients, tests the
// passing box against that plane and forwards requests to the next cell.
// ---------------------------------------------------------------------------
`include "frustum_aabb_cull_core_macros.svh"

module fac_cell #(
	parameter int             COORD_WIDTH = 32,
	parameter int             FRAC_BITS   = 16,
	parameter fac_pkg::plane_t PLANE      = fac_pkg::PL_LEFT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  fac_pkg::ctrl_t                ctrl_in,
	input  logic signed [COORD_WIDTH-1:0] value_in,
	input  logic signed [COORD_WIDTH-1:0] box_in [fac_pkg::BOX_N],
	input  fac_pkg::res_t                 res_in,
	output fac_pkg::ctrl_t                ctrl_out,
	output logic signed [COORD_WIDTH-1:0] value_out,
	output logic signed [COORD_WIDTH-1:0] box_out [fac_pkg::BOX_N],
	output fac_pkg::res_t                 res_out
);
	import fac_pkg::*;

	localparam int CFW   = COORD_WIDTH + 1;
	localparam int LO_W  = COORD_WIDTH / 2;
	localparam int HI_W  = COORD_WIDTH - LO_W;
	localparam int PL_W  = CFW + LO_W + 1;
	localparam int PH_W  = CFW + HI_W;
	localparam int PW    = 2 * COORD_WIDTH + 1;
	localparam int DW    = CFW + FRAC_BITS;
	localparam int AW0   = 2 * COORD_WIDTH + 4;
	localparam int AW1   = DW + 3;
	localparam int ACC_W = (AW0 > AW1) ? AW0 : AW1;

	localparam logic [1:0] OWN_COL = plane_col(PLANE);
	localparam coef_op_t   OWN_OP  = plane_op(PLANE);

	ctrl_t                         ctrl_q;
	logic signed [COORD_WIDTH-1:0] val_q;
	logic signed [COORD_WIDTH-1:0] box_q [BOX_N];

	logic signed [COORD_WIDTH-1:0] e3_q   [ROW_N];
	logic signed [COORD_WIDTH-1:0] ec_q   [ROW_N];
	logic signed [CFW-1:0]         coef_q [ROW_N];

	logic                  wr_en;
	logic signed [CFW-1:0] w_new;
	logic signed [CFW-1:0] e_new;
	logic signed [CFW-1:0] coef_new;

	logic signed [PL_W-1:0] pl_c  [AXES];
	logic signed [PH_W-1:0] ph_c  [AXES];
	logic signed [PL_W-1:0] pl_s1 [AXES];
	logic signed [PH_W-1:0] ph_s1 [AXES];
	logic signed [CFW-1:0]  d_s1;
	logic                   v_s1;

	logic signed [PW-1:0] prod_s2 [AXES];
	logic signed [DW-1:0] d_s2;
	logic                 v_s2;

	logic signed [ACC_W-1:0] dist_sum;
	res_t                    res_q;

	// chain stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (adv) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q <= value_in;
			box_q <= box_in;
		end
	end

	// coefficient update on a passing load
	always_comb begin
		wr_en = ctrl_q.valid && (ctrl_q.kind == KIND_LOAD);
		w_new = (ctrl_q.col == W_COL) ? CFW'(val_q) : CFW'(e3_q[ctrl_q.row]);
		e_new = (ctrl_q.col == OWN_COL) ? CFW'(val_q) : CFW'(ec_q[ctrl_q.row]);
		case (OWN_OP)
			OP_ADD:  coef_new = w_new + e_new;
			OP_SUB:  coef_new = w_new - e_new;
			OP_PASS: coef_new = e_new;
			default: coef_new = e_new;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && wr_en) begin
			if (ctrl_q.col == W_COL) begin
				e3_q[ctrl_q.row] <= val_q;
			end
			if (ctrl_q.col == OWN_COL) begin
				ec_q[ctrl_q.row] <= val_q;
			end
			if ((ctrl_q.col == W_COL) || (ctrl_q.col == OWN_COL)) begin
				coef_q[ctrl_q.row] <= coef_new;
			end
		end
	end

	// far corner select, split products
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			logic signed [COORD_WIDTH-1:0] sel;
			sel = coef_q[a][CFW-1] ? box_q[a] : box_q[AXES+a];
			pl_c[a] = coef_q[a] * $signed({1'b0, sel[LO_W-1:0]});
			ph_c[a] = coef_q[a] * $signed(sel[COORD_WIDTH-1:LO_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			res_q <= '0;
		end else if (adv) begin
			v_s1          <= ctrl_q.valid && (ctrl_q.kind == KIND_TEST);
			v_s2          <= v_s1;
			res_q.valid   <= v_s2;
			res_q.visible <= res_in.visible & ~dist_sum[ACC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s1 <= pl_c;
			ph_s1 <= ph_c;
			d_s1  <= coef_q[AXES];
			for (int a = 0; a < AXES; a++) begin
				prod_s2[a] <= (PW'(ph_s1[a]) <<< LO_W) + PW'(pl_s1[a]);
			end
			d_s2 <= DW'(d_s1) <<< FRAC_BITS;
		end
	end

	assign dist_sum = ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1]) + ACC_W'(prod_s2[2])
		+ ACC_W'(d_s2);

	assign ctrl_out  = ctrl_q;
	assign value_out = val_q;
	assign box_out   = box_q;
	assign res_out   = res_q;

	`FAC_ASSERT_IMP(a_res_aligned, PLANE != PL_LEFT, res_in.valid == v_s2)
	`FAC_ASSERT_NXT(a_load_no_test, adv && wr_en, !v_s1)
	`FAC_ASSERT_NXT(a_stall_holds, !adv, $stable(v_s1) && $stable(v_s2) && $stable(res_q.valid))

endmodule

@@ sv/frustum_aabb_cull_core.sv @@
// ---------------------------------------------------------------------------
// frustum_aabb_cull_core
// View frustum culling of axis-aligned boxes against planes taken from a
// loaded view-projection matrix.
//
// Request channel (req_valid/req_ready): kind selects a load or a box test.
// A load writes matrix element (row, col) and yields no result; a test
// carries the box bounds and yields one result on the result channel
// (res_valid/res_ready) with visible set unless some plane puts the box's
// farthest corner behind it.
// Six plane cells form a chain; requests walk it one cell per cycle
// whenever the chain advances, so loads take effect in request order
// relative to tests. Throughput: one request per cycle, set by the chain
// advancing once per cycle whenever it is not stalled.
// Stall: the result register holds a waiting result; the chain keeps
// moving while its last stage is empty, and stops only when a result in
// the last stage finds the result register still occupied.
// Reset clears all control state; the matrix store holds no defined value
// until written, and every element must be loaded before the first test.
// ---------------------------------------------------------------------------
`include "frustum_aabb_cull_core_macros.svh"

module frustum_aabb_cull_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          kind,
	input  logic [1:0]                    row,
	input  logic [1:0]                    col,
	input  logic signed [COORD_WIDTH-1:0] element_value,
	input  logic signed [COORD_WIDTH-1:0] min_x,
	input  logic signed [COORD_WIDTH-1:0] min_y,
	input  logic signed [COORD_WIDTH-1:0] min_z,
	input  logic signed [COORD_WIDTH-1:0] max_x,
	input  logic signed [COORD_WIDTH-1:0] max_y,
	input  logic signed [COORD_WIDTH-1:0] max_z,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          visible
);
	import fac_pkg::*;

	ctrl_t                         ctrl_c  [NUM_PLANES];
	logic signed [COORD_WIDTH-1:0] value_c [NUM_PLANES];
	logic signed [COORD_WIDTH-1:0] box_c   [NUM_PLANES][BOX_N];
	res_t                          res_c   [NUM_PLANES+1];

	logic adv;
	res_t end_res;
	logic res_valid_q;
	logic visible_q;

	assign end_res = res_c[NUM_PLANES];
	assign adv     = !end_res.valid || !res_valid_q || res_ready;

	assign ctrl_c[0]  = '{valid: req_valid, kind: kind, row: row, col: col};
	assign value_c[0] = element_value;
	assign box_c[0]   = '{min_x, min_y, min_z, max_x, max_y, max_z};
	assign res_c[0]   = '{valid: 1'b0, visible: 1'b1};

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
		if (p < NUM_PLANES - 1) begin : g_mid
			fac_cell #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS),
				.PLANE      (plane_t'(p))
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.ctrl_in  (ctrl_c[p]),
				.value_in (value_c[p]),
				.box_in   (box_c[p]),
				.res_in   (res_c[p]),
				.ctrl_out (ctrl_c[p+1]),
				.value_out(value_c[p+1]),
				.box_out  (box_c[p+1]),
				.res_out  (res_c[p+1])
			);
		end else begin : g_last
			fac_cell #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS),
				.PLANE      (plane_t'(p))
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.ctrl_in  (ctrl_c[p]),
				.value_in (value_c[p]),
				.box_in   (box_c[p]),
				.res_in   (res_c[p]),
				.ctrl_out (),
				.value_out(),
				.box_out  (),
				.res_out  (res_c[p+1])
			);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && end_res.valid) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_res.valid) begin
			visible_q <= end_res.visible;
		end
	end

	assign req_ready = adv;
	assign res_valid = res_valid_q;
	assign visible   = visible_q;

	`FAC_ASSERT_IMP(a_stall_cause, !req_ready, end_res.valid && res_valid && !res_ready)
	`FAC_ASSERT_NXT(a_result_loaded, end_res.valid && req_ready, res_valid)
	`FAC_ASSERT_NXT(a_result_drained, res_valid && res_ready && !end_res.valid, !res_valid)

endmodule

@@ tb/frustum_cull_checker.sv @@
// ---------------------------------------------------------------------------
// frustum_cull_checker
// Watches the request and result channels of the frustum box culling core.
// Keeps its own copy of the view-projection matrix, works out the visibility
// verdict of every accepted box test from the six clip planes, and compares
// each accepted result with the oldest verdict still waiting.
// ---------------------------------------------------------------------------
module frustum_cull_checker #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          kind,
	input  logic [1:0]                    row,
	input  logic [1:0]                    col,
	input  logic signed [COORD_WIDTH-1:0] element_value,
	input  logic signed [COORD_WIDTH-1:0] min_x,
	input  logic signed [COORD_WIDTH-1:0] min_y,
	input  logic signed [COORD_WIDTH-1:0] min_z,
	input  logic signed [COORD_WIDTH-1:0] max_x,
	input  logic signed [COORD_WIDTH-1:0] max_y,
	input  logic signed [COORD_WIDTH-1:0] max_z,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic                          visible,
	output int                            pending,
	output int                            fail_count
);
	import fac_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COORD_WIDTH+1:0] coef_t;
	typedef logic signed [127:0]           wide_t;

	coord_t view_proj [16];
	bit     verdicts [$];
	bit     oldest;
	int     mismatches = 0;

	assign fail_count = mismatches;

	function automatic coef_t plane_coef(plane_t p, int r);
		coef_t w;
		coef_t e;
		w = view_proj[r * ROW_N + W_COL];
		case (p)
			PL_LEFT:   begin e = view_proj[r * ROW_N + 0]; return w + e; end
			PL_RIGHT:  begin e = view_proj[r * ROW_N + 0]; return w - e; end
			PL_BOTTOM: begin e = view_proj[r * ROW_N + 1]; return w + e; end
			PL_TOP:    begin e = view_proj[r * ROW_N + 1]; return w - e; end
			PL_NEAR:   begin e = view_proj[r * ROW_N + 2]; return e; end
			default:   begin e = view_proj[r * ROW_N + 2]; return w - e; end
		endcase
	endfunction

	// farthest corner along each normal; exact distance, sign only
	function automatic bit box_visible(coord_t lx, coord_t ly, coord_t lz,
			coord_t hx, coord_t hy, coord_t hz);
		coord_t lo [AXES];
		coord_t hi [AXES];
		coef_t  n;
		wide_t  dist_sum;
		wide_t  nw;
		wide_t  vw;
		bit     seen;
		lo[0] = lx; lo[1] = ly; lo[2] = lz;
		hi[0] = hx; hi[1] = hy; hi[2] = hz;
		seen = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			nw = plane_coef(plane_t'(p), ROW_N - 1);
			dist_sum = nw <<< FRAC_BITS;
			for (int a = 0; a < AXES; a++) begin
				n = plane_coef(plane_t'(p), a);
				nw = n;
				vw = (n >= 0) ? hi[a] : lo[a];
				dist_sum = dist_sum + nw * vw;
			end
			if (dist_sum < 0)
				seen = 1'b0;
		end
		return seen;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t checker: result visible=%0b with no request waiting",
							$time, visible);
				end else begin
					oldest = verdicts.pop_front();
					if (visible !== oldest) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t checker: visible expected %0b got %0b",
								$time, oldest, visible);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (kind == KIND_LOAD)
					view_proj[{row, col}] = element_value;
				else
					verdicts.push_back(box_visible(min_x, min_y, min_z,
						max_x, max_y, max_z));
			end
			pending <= verdicts.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the frustum box culling core. Loads a unit-cube
// clip matrix and runs directed box tests against each plane and the range
// extremes, then random matrix reloads and box tests with random idling on
// both channels. Prediction and comparison live in frustum_cull_checker.
// ---------------------------------------------------------------------------
module tb_top;
	import fac_pkg::*;

	localparam int CW              = 32;
	localparam int FRAC            = 16;
	localparam int ONE             = 65536;
	localparam int HALF            = ONE / 2;
	localparam int MOST_NEG        = 32'sh8000_0000;
	localparam int MOST_POS        = 32'sh7fff_ffff;
	localparam int RANDOM_REQUESTS = 500;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DRAIN_CYCLES    = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	logic                 kind;
	logic [1:0]           row;
	logic [1:0]           col;
	logic signed [CW-1:0] element_value;
	logic signed [CW-1:0] min_x;
	logic signed [CW-1:0] min_y;
	logic signed [CW-1:0] min_z;
	logic signed [CW-1:0] max_x;
	logic signed [CW-1:0] max_y;
	logic signed [CW-1:0] max_z;
	logic                 res_valid;
	logic                 res_ready;
	logic                 visible;

	int pending;
	int fail_count;
	int sent = 0;
	bit req_steady = 1'b0;
	bit res_steady = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	frustum_aabb_cull_core #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FRAC)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.element_value(element_value),
		.min_x        (min_x),
		.min_y        (min_y),
		.min_z        (min_z),
		.max_x        (max_x),
		.max_y        (max_y),
		.max_z        (max_z),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.visible      (visible)
	);

	frustum_cull_checker #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FRAC)
	) u_cull_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.element_value(element_value),
		.min_x        (min_x),
		.min_y        (min_y),
		.min_z        (min_z),
		.max_x        (max_x),
		.max_y        (max_y),
		.max_z        (max_z),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.visible      (visible),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	function automatic int near_zero(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int range_edge();
		case ($urandom_range(0, 4))
			0:       return MOST_NEG;
			1:       return MOST_POS;
			2:       return 0;
			3:       return ONE;
			default: return -ONE;
		endcase
	endfunction

	// gap drives junk payload with valid low
	task automatic send_request(input logic k, input logic [1:0] r, input logic [1:0] c,
			input logic signed [CW-1:0] v, input logic signed [CW-1:0] lx,
			input logic signed [CW-1:0] ly, input logic signed [CW-1:0] lz,
			input logic signed [CW-1:0] hx, input logic signed [CW-1:0] hy,
			input logic signed [CW-1:0] hz);
		int gap;
		if ($urandom_range(0, 31) == 0)
			req_steady = !req_steady;
		gap = req_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			kind <= 1'($urandom);
			row <= 2'($urandom);
			col <= 2'($urandom);
			element_value <= $urandom;
			min_x <= $urandom;
			max_z <= $urandom;
			repeat (gap) @(posedge clk);
		end
		kind <= k;
		row <= r;
		col <= c;
		element_value <= v;
		min_x <= lx;
		min_y <= ly;
		min_z <= lz;
		max_x <= hx;
		max_y <= hy;
		max_z <= hz;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	task automatic load_element(input int r, input int c, input int v);
		send_request(KIND_LOAD, 2'(r), 2'(c), v, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
	endtask

	task automatic test_box(input int lx, input int ly, input int lz,
			input int hx, input int hy, input int hz);
		send_request(KIND_TEST, 2'($urandom), 2'($urandom), $urandom,
			lx, ly, lz, hx, hy, hz);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		res_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			if ($urandom_range(0, 31) == 0)
				res_steady = !res_steady;
			stall = res_steady ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL frustum_aabb_cull_core");
		$finish;
	end

	initial begin : stimulus
		int lo [3];
		int hi [3];
		int t;
		int mat_style;
		int box_style;
		bit wild_matrix;
		bit paused;
		wild_matrix = 1'b0;
		paused = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		kind <= KIND_LOAD;
		row <= '0;
		col <= '0;
		element_value <= '0;
		min_x <= '0;
		min_y <= '0;
		min_z <= '0;
		max_x <= '0;
		max_y <= '0;
		max_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit-cube clip volume: x,y in [-1,1], z in [0,1], w = 1
		for (int r = 0; r < ROW_N; r++)
			for (int c = 0; c < ROW_N; c++)
				load_element(r, c, (r == c) ? ONE : 0);
		test_box(-HALF, -HALF, ONE / 4, HALF, HALF, 3 * ONE / 4);
		test_box(-3 * ONE, -HALF, ONE / 4, -2 * ONE, HALF, 3 * ONE / 4);
		test_box(2 * ONE, -HALF, ONE / 4, 3 * ONE, HALF, 3 * ONE / 4);
		test_box(-HALF, -3 * ONE, ONE / 4, HALF, -2 * ONE, 3 * ONE / 4);
		test_box(-HALF, 2 * ONE, ONE / 4, HALF, 3 * ONE, 3 * ONE / 4);
		test_box(-HALF, -HALF, -2 * ONE, HALF, HALF, -ONE);
		test_box(-HALF, -HALF, 2 * ONE, HALF, HALF, 3 * ONE);
		test_box(-3 * ONE, -HALF, ONE / 4, 0, 3 * ONE, 3 * ONE / 4);
		test_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
		test_box(2 * ONE, -HALF, ONE / 4, -2 * ONE, HALF, 3 * ONE / 4);
		test_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		test_box(ONE, ONE, ONE, ONE, ONE, ONE);
		load_element(0, 0, MOST_NEG);
		load_element(0, 3, MOST_POS);
		load_element(3, 3, MOST_POS);
		test_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
		test_box(0, 0, 0, 0, 0, 0);
		test_box(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG);

		mat_style = 0;
		while (sent < RANDOM_REQUESTS + 40) begin
			if (!paused && sent >= RANDOM_REQUESTS / 2) begin
				hold_until_drained();
				paused = 1'b1;
			end
			if (mat_style >= 0) begin
				wild_matrix = (mat_style == 7);
				if (mat_style >= 8) begin
					repeat ($urandom_range(1, 4))
						load_element($urandom_range(0, 3), $urandom_range(0, 3),
							$urandom_range(0, 1) ? int'($urandom) : near_zero(2 * ONE));
				end else begin
					for (int r = 0; r < ROW_N; r++)
						for (int c = 0; c < ROW_N; c++) begin
							if (mat_style == 7)
								t = $urandom;
							else if (r == c && r < 3)
								t = $urandom_range(ONE / 4, 4 * ONE);
							else if (r == 3 && c == 3)
								t = $urandom_range(HALF, 2 * ONE);
							else if (r == 3)
								t = near_zero(ONE);
							else
								t = ($urandom_range(0, 3) == 0) ? near_zero(ONE / 4) : 0;
							load_element(r, c, t);
						end
				end
			end
			mat_style = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 9) : -1;

			box_style = $urandom_range(0, 9);
			if (wild_matrix && box_style < 5)
				box_style = 8;
			for (int a = 0; a < 3; a++) begin
				if (box_style < 8) begin
					lo[a] = near_zero(4 * ONE);
					hi[a] = lo[a] + int'($urandom_range(0, 3 * ONE));
				end else if (box_style == 8) begin
					lo[a] = $urandom;
					hi[a] = $urandom;
				end else begin
					lo[a] = range_edge();
					hi[a] = range_edge();
				end
				if ($urandom_range(0, 15) == 0) begin
					t = lo[a];
					lo[a] = hi[a];
					hi[a] = t;
				end
			end
			test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS frustum_aabb_cull_core");
		else
			$display("FAIL frustum_aabb_cull_core");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/fac_pkg.sv
sv/fac_cell.sv
sv/frustum_aabb_cull_core.sv
tb/frustum_cull_checker.sv
tb/tb_top.sv
